/* rtl/wbmp_pkg.sv */
// Shared types and constants for the WBMP stream decoder.
// Used by the parser, the command queue, the pixel expander and the top level.
// No dependencies.
`default_nettype none

package wbmp_pkg;

  // Default dimension width of the decoder
  localparam int DimBitsDefault = 16;

  // Reported field widths
  localparam int OutDimW   = 16;
  localparam int PixW      = 8;
  localparam int ErrW      = 3;
  localparam int PixPerByte = 8;
  localparam int CntW      = 4;
  localparam int IdxW      = 3;

  // Output stream packing
  localparam int TdataW = 80;
  localparam int TuserW = 3;

  // Command queue depth (power of two)
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    KIND_DIM = 2'd0,
    KIND_PIX = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_TYPE  = 3'd1,
    ERR_EXT   = 3'd2,
    ERR_DIM   = 3'd3,
    ERR_TRUNC = 3'd4
  } err_t;

  // One command from parser to expander. For a dimensions command, col and
  // row carry the width and height.
  typedef struct packed {
    kind_t              kind;
    logic [PixW-1:0]    pix_byte;
    logic [OutDimW-1:0] col;
    logic [OutDimW-1:0] row;
    err_t               err;
    logic [CntW-1:0]    cnt;
    logic               img_last;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/wbmp_parser.sv */
// Front end: accepts file bytes, parses the WBMP header and tracks pixel
// position, emitting one command per result group. Depends on wbmp_pkg.
`default_nettype none

module wbmp_parser #(
  parameter int DIM_BITS = wbmp_pkg::DimBitsDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          start_of_file,
  input  wire logic          end_of_stream,
  input  wire logic          q_full,
  output logic               push,
  output wbmp_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_HDR   = 3'd1,
    PH_PARAM = 3'd2,
    PH_SKIP  = 3'd3,
    PH_WID   = 3'd4,
    PH_HEI   = 3'd5,
    PH_PIX   = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  localparam logic [DIM_BITS-1:0] DimOne   = DIM_BITS'(1);
  localparam logic [DIM_BITS-1:0] DimEight = DIM_BITS'(wbmp_pkg::PixPerByte);

  phase_t              phase, phase_next;
  logic [DIM_BITS-1:0] acc, acc_next;
  logic                type_nz, type_nz_next;
  logic [4:0]          skip, skip_next;
  logic [DIM_BITS-1:0] img_w, img_w_next;
  logic [DIM_BITS-1:0] img_h, img_h_next;
  logic [DIM_BITS-1:0] col, col_next;
  logic [DIM_BITS-1:0] row, row_next;

  // State as seen after an optional restart
  phase_t              eff_phase;
  logic [DIM_BITS-1:0] eff_acc, eff_w, eff_h, eff_col, eff_row;
  logic                eff_type_nz;
  logic [4:0]          eff_skip;

  logic                accept;
  logic [DIM_BITS-1:0] acc_shift;
  logic                acc_ovf;
  logic [DIM_BITS-1:0] left;
  logic [wbmp_pkg::CntW-1:0] cnt;
  logic [DIM_BITS-1:0] col_adv;
  logic                row_end;
  logic                img_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Apply restart before handling the byte
  always_comb begin
    if (start_of_file) begin
      eff_phase   = PH_TYPE;
      eff_acc     = '0;
      eff_type_nz = 1'b0;
      eff_skip    = '0;
      eff_w       = '0;
      eff_h       = '0;
      eff_col     = '0;
      eff_row     = '0;
    end else begin
      eff_phase   = phase;
      eff_acc     = acc;
      eff_type_nz = type_nz;
      eff_skip    = skip;
      eff_w       = img_w;
      eff_h       = img_h;
      eff_col     = col;
      eff_row     = row;
    end
  end

  // Continuation-coded number step and overflow check
  assign acc_shift = {eff_acc[DIM_BITS-8:0], data_byte[6:0]};
  assign acc_ovf   = |eff_acc[DIM_BITS-1 -: 7];

  // Pixel count for this byte and position advance
  assign left    = eff_w - eff_col;
  assign cnt     = (left < DimEight) ? left[wbmp_pkg::CntW-1:0]
                                     : wbmp_pkg::CntW'(wbmp_pkg::PixPerByte);
  assign col_adv = eff_col + DIM_BITS'(cnt);
  assign row_end = (col_adv == eff_w);
  assign img_end = row_end && (eff_row == (eff_h - DimOne));

  // Classify the item
  always_comb begin
    phase_next   = eff_phase;
    acc_next     = eff_acc;
    type_nz_next = eff_type_nz;
    skip_next    = eff_skip;
    img_w_next   = eff_w;
    img_h_next   = eff_h;
    col_next     = eff_col;
    row_next     = eff_row;
    push         = 1'b0;
    cmd          = '0;
    cmd.kind     = wbmp_pkg::KIND_ERR;
    cmd.err      = wbmp_pkg::ERR_NONE;
    cmd.cnt      = wbmp_pkg::CntW'(1);

    if (end_of_stream) begin
      if (eff_phase != PH_DONE) begin
        push       = accept;
        cmd.err    = wbmp_pkg::ERR_TRUNC;
        phase_next = PH_DONE;
      end
    end else begin
      case (eff_phase)
        PH_TYPE: begin
          if (|data_byte[6:0]) begin
            type_nz_next = 1'b1;
          end
          if (!data_byte[7]) begin
            if (type_nz_next) begin
              push       = accept;
              cmd.err    = wbmp_pkg::ERR_TYPE;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          case (data_byte[7:6])
            2'b00: begin
              phase_next = PH_WID;
              acc_next   = '0;
            end
            2'b11: phase_next = PH_PARAM;
            default: begin
              push       = accept;
              cmd.err    = wbmp_pkg::ERR_EXT;
              phase_next = PH_DONE;
            end
          endcase
        end
        PH_PARAM: begin
          skip_next  = 5'(data_byte[6:4]) + 5'(data_byte[3:0]);
          phase_next = (skip_next != 5'd0) ? PH_SKIP : PH_HDR;
        end
        PH_SKIP: begin
          skip_next = eff_skip - 5'd1;
          if (skip_next == 5'd0) begin
            phase_next = PH_HDR;
          end
        end
        PH_WID, PH_HEI: begin
          acc_next = acc_shift;
          if (acc_ovf) begin
            push       = accept;
            cmd.err    = wbmp_pkg::ERR_DIM;
            phase_next = PH_DONE;
          end else if (!data_byte[7]) begin
            acc_next = '0;
            if (eff_phase == PH_WID) begin
              img_w_next = acc_shift;
              phase_next = PH_HEI;
            end else begin
              img_h_next   = acc_shift;
              col_next     = '0;
              row_next     = '0;
              push         = accept;
              cmd.kind     = wbmp_pkg::KIND_DIM;
              cmd.col      = wbmp_pkg::OutDimW'(eff_w);
              cmd.row      = wbmp_pkg::OutDimW'(acc_shift);
              cmd.img_last = (eff_w == '0) || (acc_shift == '0);
              phase_next   = cmd.img_last ? PH_DONE : PH_PIX;
            end
          end
        end
        PH_PIX: begin
          push         = accept;
          cmd.kind     = wbmp_pkg::KIND_PIX;
          cmd.pix_byte = data_byte;
          cmd.col      = wbmp_pkg::OutDimW'(eff_col);
          cmd.row      = wbmp_pkg::OutDimW'(eff_row);
          cmd.cnt      = cnt;
          cmd.img_last = img_end;
          if (row_end) begin
            col_next = '0;
            row_next = eff_row + DimOne;
          end else begin
            col_next = col_adv;
          end
          if (img_end) begin
            phase_next = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold parser state; advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_TYPE;
      acc     <= '0;
      type_nz <= 1'b0;
      skip    <= '0;
      img_w   <= '0;
      img_h   <= '0;
      col     <= '0;
      row     <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      acc     <= acc_next;
      type_nz <= type_nz_next;
      skip    <= skip_next;
      img_w   <= img_w_next;
      img_h   <= img_h_next;
      col     <= col_next;
      row     <= row_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/wbmp_cmd_fifo.sv */
// Short command queue between parser and expander.
// Register-based, first-word fall-through. Depends on wbmp_pkg.
`default_nettype none

module wbmp_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wbmp_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output wbmp_pkg::cmd_t      head
);

  wbmp_pkg::cmd_t                entries [wbmp_pkg::FifoDepth];
  logic [wbmp_pkg::FifoPtrW-1:0] wr_ptr, rd_ptr;
  logic [wbmp_pkg::FifoPtrW:0]   count;
  logic                          do_push, do_pop;

  assign full      = (count == (wbmp_pkg::FifoPtrW+1)'(wbmp_pkg::FifoDepth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/wbmp_expander.sv */
// Back end: turns queued commands into result items, one per cycle while the
// output is not stalled, into a registered output stage. Depends on wbmp_pkg.
`default_nettype none

module wbmp_expander (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_not_empty,
  input  wire wbmp_pkg::cmd_t               q_head,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [wbmp_pkg::TdataW-1:0]       m_tdata,
  output logic [wbmp_pkg::TuserW-1:0]       m_tuser,
  output logic                              m_tlast
);

  wbmp_pkg::cmd_t                cur;
  logic                          cur_valid;
  logic [wbmp_pkg::IdxW-1:0]     idx;
  logic                          slot_free;
  logic                          emit;
  logic                          last_idx;

  logic [wbmp_pkg::PixW-1:0]     f_pix;
  logic [wbmp_pkg::OutDimW-1:0]  f_col, f_row, f_w, f_h;
  logic [wbmp_pkg::ErrW-1:0]     f_err;

  assign slot_free = !m_tvalid || m_tready;
  assign emit      = slot_free && cur_valid;
  assign last_idx  = ((wbmp_pkg::CntW'(idx) + wbmp_pkg::CntW'(1)) == cur.cnt);
  assign q_pop     = q_not_empty && (!cur_valid || (emit && last_idx));

  // Build the result fields for the current position
  always_comb begin
    f_pix = '0;
    f_col = '0;
    f_row = '0;
    f_w   = '0;
    f_h   = '0;
    f_err = wbmp_pkg::ERR_NONE;
    case (cur.kind)
      wbmp_pkg::KIND_PIX: begin
        f_pix = cur.pix_byte[3'd7 - idx] ? 8'hff : 8'h00;
        f_col = cur.col + wbmp_pkg::OutDimW'(idx);
        f_row = cur.row;
      end
      wbmp_pkg::KIND_DIM: begin
        f_w = cur.col;
        f_h = cur.row;
      end
      default: f_err = cur.err;
    endcase
  end

  // Hold the active command and step through its pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (slot_free) begin
        m_tvalid <= cur_valid;
      end
      if (q_pop || (emit && last_idx)) begin
        idx <= '0;
      end else if (emit) begin
        idx <= idx + 1'b1;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (emit && last_idx) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // Load command payload and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (emit) begin
      m_tdata <= {5'd0, f_err, f_h, f_w, f_row, f_col, f_pix};
      m_tuser <= {cur.img_last && last_idx, cur.kind};
      m_tlast <= last_idx;
    end
  end

endmodule

`default_nettype wire

/* rtl/wbmp_stream_decoder.sv */
// WBMP type 0 stream decoder: one file byte in, dimensions, pixels or errors out.
// Results are registered: queue entry, expander current command, then output stage.
// Throughput: one input byte per cycle while the 4-entry command queue has room;
// one result per cycle out while m_tready allows; a pixel byte yields 1 to 8 results.
// Reset (rst, synchronous): parser awaits the type field, queue empties, no output.
// Depends on wbmp_pkg, wbmp_parser, wbmp_cmd_fifo, wbmp_expander.
`default_nettype none

module wbmp_stream_decoder #(
  parameter int DIM_BITS = wbmp_pkg::DimBitsDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,  // [7:0] data_byte
  input  wire logic                         s_tuser,  // [0] start_of_file
  input  wire logic                         s_tlast,  // end_of_stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [7:0] pixel_value, [23:8] column, [39:24] row, [55:40] width,
  // [71:56] height, [74:72] error_code, [79:75] zero
  output logic [wbmp_pkg::TdataW-1:0]       m_tdata,
  output logic [wbmp_pkg::TuserW-1:0]       m_tuser,  // [1:0] kind, [2] last_of_image
  output logic                              m_tlast   // last_in_run
);

  logic           q_full, q_not_empty, q_pop, push;
  wbmp_pkg::cmd_t push_cmd, q_head;

  wbmp_parser #(
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .data_byte     (s_tdata),
    .start_of_file (s_tuser),
    .end_of_stream (s_tlast),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  wbmp_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  wbmp_expander u_expander (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire
